FILE: rtl/rfl_pkg.sv
// rfl_pkg: shared types, widths and saturation helper for the resonant lowpass
// used by rfl_mul and resonant_four_pole_lowpass; no dependencies
package rfl_pkg;

	localparam int STATE_BITS       = 40;
	localparam int DIFF_BITS        = STATE_BITS + 1;
	localparam int SUM_BITS         = STATE_BITS + 2;
	localparam int DIGIT_BITS       = 4;
	localparam int DEF_SAMPLE_BITS  = 24;
	localparam int DEF_COEF_BITS    = 16;

	typedef logic signed [STATE_BITS-1:0] state_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;

	localparam state_t STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
	localparam state_t STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

	// clip a sum back into the state range
	function automatic state_t sat_sum(input sum_t v);
		logic [SUM_BITS-STATE_BITS:0] hi;
		hi = v[SUM_BITS-1:STATE_BITS-1];
		if (hi == '0 || hi == '1)
			return v[STATE_BITS-1:0];
		else
			return v[SUM_BITS-1] ? STATE_MIN : STATE_MAX;
	endfunction

endpackage

FILE: rtl/rfl_div.sv
// rfl_div: restoring radix-2 divider, one quotient bit per cycle
// standalone; used by resonant_four_pole_lowpass for the feedback gain
module rfl_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] rem_sub;
	logic           ge;

	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
			end else if (busy_q) begin
				rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: rtl/rfl_mul.sv
// rfl_mul: shared signed-by-unsigned multiplier, four coefficient bits per cycle,
// then floor shift by the coefficient scale and clip to state range; uses rfl_pkg
module rfl_mul #(
	parameter int  COEF_BITS = rfl_pkg::DEF_COEF_BITS,
	parameter int  B_W       = 2 * rfl_pkg::DEF_COEF_BITS + 2,
	localparam int NDIG      = (B_W + rfl_pkg::DIGIT_BITS - 1) / rfl_pkg::DIGIT_BITS,
	localparam int IDX_W     = (NDIG > 1) ? $clog2(NDIG) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rfl_pkg::diff_t       a,
	input  logic [B_W-1:0]       b,
	input  logic [IDX_W-1:0]     top_dig,
	output logic                 done,
	output rfl_pkg::state_t      res
);

	localparam int B_PAD = NDIG * rfl_pkg::DIGIT_BITS;
	localparam int P_W   = rfl_pkg::DIFF_BITS + B_PAD;
	localparam int SH_W  = P_W + 1 - COEF_BITS;
	localparam int HI_W  = SH_W - rfl_pkg::STATE_BITS + 1;
	localparam int PT_W  = rfl_pkg::DIFF_BITS + rfl_pkg::DIGIT_BITS;

	typedef enum logic [1:0] {
		M_IDLE,
		M_RUN,
		M_FIN
	} mul_state_t;

	mul_state_t                      st_q;
	logic                            neg_q;
	logic [rfl_pkg::DIFF_BITS-1:0]   mag_q;
	logic [B_PAD-1:0]                b_q;
	logic [IDX_W-1:0]                idx_q;
	logic [P_W-1:0]                  acc_q;
	rfl_pkg::state_t                 res_q;
	logic                            done_q;

	logic [rfl_pkg::DIFF_BITS-1:0]   a_mag;
	logic [rfl_pkg::DIGIT_BITS-1:0]  digit;
	logic [PT_W-1:0]                 part;
	logic [P_W-1:0]                  acc_nxt;
	logic signed [P_W:0]             sp;
	logic [SH_W-1:0]                 sh;
	logic [HI_W-1:0]                 hi;
	rfl_pkg::state_t                 sat;

	assign a_mag   = a[rfl_pkg::DIFF_BITS-1] ? -a : a;
	assign digit   = b_q[idx_q*rfl_pkg::DIGIT_BITS +: rfl_pkg::DIGIT_BITS];
	assign part    = mag_q * digit;
	assign acc_nxt = (acc_q << rfl_pkg::DIGIT_BITS) + P_W'(part);

	// signed product, floor shift, clip
	always_comb begin
		sp = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
		sh = sp[P_W:COEF_BITS];
		hi = sh[SH_W-1:rfl_pkg::STATE_BITS-1];
		if (hi == '0 || hi == '1)
			sat = sh[rfl_pkg::STATE_BITS-1:0];
		else
			sat = sh[SH_W-1] ? rfl_pkg::STATE_MIN : rfl_pkg::STATE_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			neg_q  <= 1'b0;
			mag_q  <= '0;
			b_q    <= '0;
			idx_q  <= '0;
			acc_q  <= '0;
			res_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				M_IDLE: begin
					if (start) begin
						neg_q <= a[rfl_pkg::DIFF_BITS-1];
						mag_q <= a_mag;
						b_q   <= B_PAD'(b);
						idx_q <= top_dig;
						acc_q <= '0;
						st_q  <= M_RUN;
					end
				end
				M_RUN: begin
					acc_q <= acc_nxt;
					if (idx_q == '0)
						st_q <= M_FIN;
					else
						idx_q <= idx_q - 1'b1;
				end
				M_FIN: begin
					res_q  <= sat;
					done_q <= 1'b1;
					st_q   <= M_IDLE;
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: rtl/resonant_four_pole_lowpass.sv
// resonant_four_pole_lowpass: top level, sequencer and filter state
// uses rfl_pkg, rfl_div and rfl_mul
//
// usage
//   s_tdata carries one audio sample and its cutoff coefficient per beat;
//   m_tdata returns the fourth stage output, one beat per input beat. The
//   user loads resonance via cfg_we/cfg_wdata only while idle; unchecked.
// timing
//   each beat runs one divide for the feedback gain, then five multiplies
//   on one shared unit, four coefficient bits a cycle: one by the gain,
//   four by the cutoff.
//   s_tready is high only between beats; one beat is worked at a time.
// reset
//   the four stage values and the resonance clear to zero, no beat pending.
// stall
//   a finished beat waits in the output register; the next input beat is
//   taken meanwhile and its result waits until m_tready frees the register.
module resonant_four_pole_lowpass #(
	parameter int  SAMPLE_BITS = rfl_pkg::DEF_SAMPLE_BITS,
	parameter int  COEF_BITS   = rfl_pkg::DEF_COEF_BITS,
	localparam int IN_W        = ((SAMPLE_BITS + COEF_BITS + 7) / 8) * 8,
	localparam int OUT_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COEF_BITS:0] cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // sample_in, cutoff
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata    // sample_out
);

	localparam int NUM_W   = 2 * COEF_BITS + 1;
	localparam int FB_W    = 2 * COEF_BITS + 2;
	localparam int NDIG_FB = (FB_W + rfl_pkg::DIGIT_BITS - 1) / rfl_pkg::DIGIT_BITS;
	localparam int NDIG_F  = (COEF_BITS + rfl_pkg::DIGIT_BITS - 1) / rfl_pkg::DIGIT_BITS;
	localparam int IDX_W   = (NDIG_FB > 1) ? $clog2(NDIG_FB) : 1;
	localparam int Y_HI_W  = rfl_pkg::STATE_BITS - SAMPLE_BITS + 1;

	localparam longint unsigned COEF_ONE = 64'd1 << COEF_BITS;
	localparam logic [COEF_BITS-1:0] COEF_LO = COEF_BITS'(COEF_ONE / 100);
	localparam logic [COEF_BITS-1:0] COEF_HI = COEF_BITS'((COEF_ONE * 99) / 100);
	localparam logic [IDX_W-1:0] DIG_FB = IDX_W'(NDIG_FB - 1);
	localparam logic [IDX_W-1:0] DIG_F  = IDX_W'(NDIG_F - 1);
	localparam logic [1:0] LAST_STAGE = 2'd3;
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FB,
		ST_STG,
		ST_OUT
	} seq_state_t;

	seq_state_t                     state_q;
	logic [1:0]                     stg_q;
	logic [COEF_BITS:0]             res_q;
	logic signed [SAMPLE_BITS-1:0]  x_q;
	logic [COEF_BITS-1:0]           f_q;
	rfl_pkg::state_t                s_q [4];
	logic                           m_tvalid_q;
	logic [SAMPLE_BITS-1:0]         m_tdata_q;

	logic [COEF_BITS-1:0]           cut_in;
	logic [COEF_BITS-1:0]           f_clamp;
	logic [COEF_BITS-1:0]           den;
	logic [NUM_W-1:0]               num;
	logic [NUM_W-1:0]               quo;
	logic [FB_W-1:0]                fb;
	logic                           div_start;
	logic                           div_done;
	logic                           mul_start;
	logic                           mul_done;
	rfl_pkg::diff_t                 mul_a;
	logic [FB_W-1:0]                mul_b;
	logic [IDX_W-1:0]               mul_top;
	rfl_pkg::state_t                mul_res;
	rfl_pkg::diff_t                 diff0;
	rfl_pkg::diff_t                 diff_nx;
	rfl_pkg::state_t                t_sat;
	rfl_pkg::state_t                nv;
	logic [Y_HI_W-1:0]              y_hi;
	logic [SAMPLE_BITS-1:0]         y;
	logic                           out_load;

	assign cut_in  = s_tdata[SAMPLE_BITS +: COEF_BITS];
	assign f_clamp = (cut_in < COEF_LO) ? COEF_LO : ((cut_in > COEF_HI) ? COEF_HI : cut_in);
	// one minus f, never zero after the clamp
	assign den     = -f_clamp;
	assign num     = {res_q, {COEF_BITS{1'b0}}};
	assign fb      = FB_W'(res_q) + FB_W'(quo);

	assign div_start = (state_q == ST_IDLE) && s_tvalid;

	assign diff0   = rfl_pkg::diff_t'(s_q[0]) - rfl_pkg::diff_t'(s_q[1]);
	assign t_sat   = rfl_pkg::sat_sum(rfl_pkg::sum_t'(x_q) - rfl_pkg::sum_t'(s_q[0])
		+ rfl_pkg::sum_t'(mul_res));
	assign nv      = rfl_pkg::sat_sum(rfl_pkg::sum_t'(s_q[0]) + rfl_pkg::sum_t'(mul_res));
	assign diff_nx = rfl_pkg::diff_t'(nv) - rfl_pkg::diff_t'(s_q[1]);

	assign y_hi = s_q[3][rfl_pkg::STATE_BITS-1:SAMPLE_BITS-1];
	assign y    = (y_hi == '0 || y_hi == '1) ? s_q[3][SAMPLE_BITS-1:0] :
		(s_q[3][rfl_pkg::STATE_BITS-1] ? SMP_MIN : SMP_MAX);

	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// operand select for the shared multiplier
	always_comb begin
		mul_start = 1'b0;
		mul_a     = diff0;
		mul_b     = fb;
		mul_top   = DIG_FB;
		case (state_q)
			ST_DIV: begin
				mul_start = div_done;
			end
			ST_FB: begin
				mul_start = mul_done;
				mul_a     = rfl_pkg::diff_t'(t_sat);
				mul_b     = FB_W'(f_q);
				mul_top   = DIG_F;
			end
			ST_STG: begin
				mul_start = mul_done && (stg_q != LAST_STAGE);
				mul_a     = diff_nx;
				mul_b     = FB_W'(f_q);
				mul_top   = DIG_F;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	rfl_div #(
		.NUM_W (NUM_W),
		.DEN_W (COEF_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	rfl_mul #(
		.COEF_BITS (COEF_BITS),
		.B_W       (FB_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.top_dig (mul_top),
		.done    (mul_done),
		.res     (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			stg_q      <= '0;
			res_q      <= '0;
			x_q        <= '0;
			f_q        <= '0;
			s_q[0]     <= '0;
			s_q[1]     <= '0;
			s_q[2]     <= '0;
			s_q[3]     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_we)
				res_q <= cfg_wdata;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						x_q     <= s_tdata[SAMPLE_BITS-1:0];
						f_q     <= f_clamp;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_FB;
				end
				ST_FB: begin
					if (mul_done) begin
						stg_q   <= '0;
						state_q <= ST_STG;
					end
				end
				ST_STG: begin
					if (mul_done) begin
						// rotate so the stage in work always sits at the head
						s_q[0] <= s_q[1];
						s_q[1] <= s_q[2];
						s_q[2] <= s_q[3];
						s_q[3] <= nv;
						if (stg_q == LAST_STAGE)
							state_q <= ST_OUT;
						else
							stg_q <= stg_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_tdata_q  <= y;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'(m_tdata_q);

`ifndef SYNTHESIS
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside its wait state");

	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_FB || state_q == ST_STG))
		else $error("multiplier finished outside a wait state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_DIV && !s_tready)
		else $error("accepted beat did not start the divide");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && m_tvalid && !m_tready |=> state_q == ST_OUT)
		else $error("pending result overwritten");
`endif

endmodule

FILE: dv/resonant_four_pole_lowpass_test.sv
// resonant_four_pole_lowpass_test: self-checking bench for the resonant four-pole lowpass
// sends sample and cutoff beats under random idling and checks each output against a
// fixed-point prediction of the filter; depends on rfl_pkg and resonant_four_pole_lowpass
module resonant_four_pole_lowpass_test;

	localparam int SMP_W  = rfl_pkg::DEF_SAMPLE_BITS;
	localparam int COEF_W = rfl_pkg::DEF_COEF_BITS;
	localparam int IN_W   = ((SMP_W + COEF_W + 7) / 8) * 8;
	localparam int OUT_W  = ((SMP_W + 7) / 8) * 8;

	typedef logic signed [127:0]     wide_t;
	typedef logic [COEF_W:0]         res_t;
	typedef logic [COEF_W-1:0]       coef_t;
	typedef logic signed [SMP_W-1:0] smp_t;

	localparam coef_t CUT_LO  = COEF_W'((1 << COEF_W) / 100);
	localparam coef_t CUT_HI  = COEF_W'((99 * (1 << COEF_W)) / 100);
	localparam res_t  RES_MAX = '1;
	localparam smp_t  SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam smp_t  SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
	localparam wide_t WIDE_ST_MAX  = rfl_pkg::STATE_MAX;
	localparam wide_t WIDE_ST_MIN  = rfl_pkg::STATE_MIN;
	localparam wide_t WIDE_SMP_MAX = SMP_MAX;
	localparam wide_t WIDE_SMP_MIN = SMP_MIN;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	res_t             cfg_wdata = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata   = '0;   // sample_in, cutoff
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;          // sample_out

	res_t             resonance_q = '0;
	rfl_pkg::state_t  stage_q[4]  = '{default: '0};
	logic [SMP_W-1:0] out_samples_due[$];
	int         mismatches    = 0;
	int         src_idle_pct  = 0;
	int         snk_stall_pct = 0;

	resonant_four_pole_lowpass #(
		.SAMPLE_BITS(SMP_W),
		.COEF_BITS  (COEF_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rfl_pkg::state_t clip_state(wide_t v);
		if (v > WIDE_ST_MAX)
			return rfl_pkg::STATE_MAX;
		if (v < WIDE_ST_MIN)
			return rfl_pkg::STATE_MIN;
		return v[rfl_pkg::STATE_BITS-1:0];
	endfunction

	// floor of v * coef / 2^COEF_W, clipped to the state range
	function automatic rfl_pkg::state_t scale_q16(wide_t v, wide_t coef);
		return clip_state((v * coef) >>> COEF_W);
	endfunction

	function automatic logic [SMP_W-1:0] lowpass_next_output(smp_t x, coef_t cut);
		wide_t f, res, gain, drive, y;
		f = cut;
		if (f < CUT_LO)
			f = CUT_LO;
		if (f > CUT_HI)
			f = CUT_HI;
		res   = resonance_q;
		gain  = res + (res <<< COEF_W) / ((wide_t'(1) <<< COEF_W) - f);
		drive = clip_state(wide_t'(x) - stage_q[0] +
			scale_q16(wide_t'(stage_q[0]) - stage_q[1], gain));
		stage_q[0] = clip_state(wide_t'(stage_q[0]) + scale_q16(drive, f));
		for (int i = 1; i < 4; i++)
			stage_q[i] = clip_state(wide_t'(stage_q[i]) +
				scale_q16(wide_t'(stage_q[i-1]) - stage_q[i], f));
		y = stage_q[3];
		if (y > WIDE_SMP_MAX)
			y = WIDE_SMP_MAX;
		if (y < WIDE_SMP_MIN)
			y = WIDE_SMP_MIN;
		return y[SMP_W-1:0];
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		logic [SMP_W-1:0] due;
		if (m_tvalid && m_tready) begin
			if (out_samples_due.size() == 0) begin
				report_mismatch($sformatf("output beat %h with nothing due", m_tdata));
			end else begin
				due = out_samples_due.pop_front();
				if (m_tdata[SMP_W-1:0] !== due)
					report_mismatch($sformatf("sample_out %h, predicted %h",
						m_tdata[SMP_W-1:0], due));
			end
		end
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	task automatic send_beat(smp_t smp, coef_t cut);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({cut, smp});
		do @(posedge clk); while (!s_tready);
		out_samples_due.push_back(lowpass_next_output(smp, cut));
	endtask

	task automatic await_outputs();
		s_tvalid <= 1'b0;
		while (out_samples_due.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic load_resonance(res_t value);
		await_outputs();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		resonance_q = value;
	endtask

	// cutoff either side of both clamp bounds, full-scale input, then runaway resonance
	task automatic test_extremes();
		coef_t cut_edges[8];
		cut_edges = '{16'd0, 16'd654, 16'd655, 16'd656,
			16'd64879, 16'd64880, 16'd64881, 16'hffff};
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		load_resonance('0);
		send_beat('0, '0);
		for (int i = 0; i < 8; i++)
			send_beat(i[0] ? SMP_MIN : SMP_MAX, cut_edges[i]);
		send_beat('1, 16'h8000);
		load_resonance(RES_MAX);
		for (int i = 0; i < 8; i++)
			send_beat(i < 4 ? SMP_MAX : SMP_MIN, 16'hffff);
		send_beat(SMP_MAX, CUT_LO);
		send_beat(SMP_MIN, CUT_HI);
		send_beat('0, 16'hffff);
	endtask

	task automatic test_random_beats(int idle_pct, int stall_pct, res_t res, int count);
		smp_t  smp;
		coef_t cut;
		smp = '0;
		load_resonance(res);
		src_idle_pct  = idle_pct;
		snk_stall_pct = stall_pct;
		repeat (count) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: smp = SMP_W'($urandom);
				5:             smp = SMP_MAX;
				6:             smp = SMP_MIN;
				7, 8:          smp = SMP_W'(int'($urandom_range(4000)) - 2000);
				default:       ;  // hold the previous level
			endcase
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: cut = COEF_W'($urandom);
				6, 7:             cut = COEF_W'($urandom_range(800));
				default:          cut = COEF_W'($urandom_range(65535, 64700));
			endcase
			send_beat(smp, cut);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_random_beats(0, 0, '0, 160);
		test_random_beats(0, 0, RES_MAX, 160);
		test_random_beats(76, 0, res_t'($urandom), 160);
		test_random_beats(76, 0, 17'h10000, 160);
		test_random_beats(0, 76, res_t'($urandom), 160);
		test_random_beats(0, 76, 17'd1, 160);
		test_random_beats(34, 34, res_t'($urandom), 160);
		test_random_beats(34, 34, RES_MAX, 160);
		await_outputs();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("[resonant_four_pole_lowpass] OK");
		else
			$display("[resonant_four_pole_lowpass] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[resonant_four_pole_lowpass] ERROR");
		$finish;
	end

endmodule
